### design/wsrm_pkg.sv
// package: word types, command codes and the star closure function for the regex matcher
`default_nettype none
package wsrm_pkg;

  localparam int MAX_TOKENS = 16;
  localparam int NPOS       = MAX_TOKENS + 1;
  localparam int CNT_W      = $clog2(NPOS);
  localparam int TOK_IDX_W  = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1;
  localparam int LEVELS     = $clog2(NPOS);

  localparam logic [7:0] CH_DOT  = 8'h2E;
  localparam logic [7:0] CH_STAR = 8'h2A;

  // input kind codes
  localparam logic [1:0] KIND_APPEND  = 2'd0;
  localparam logic [1:0] KIND_SUBJECT = 2'd1;
  localparam logic [1:0] KIND_END     = 2'd2;
  localparam logic [1:0] KIND_CLEAR   = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    logic matched;
    logic pattern_error;
  } out_word_t;

  typedef enum logic [2:0] {
    OP_TOKEN,
    OP_STAR,
    OP_SUBJECT,
    OP_END,
    OP_CLEAR
  } op_t;

  // classified word as it sits in the queue
  typedef struct packed {
    op_t        op;
    logic       is_dot;
    logic [7:0] data_byte;
  } cmd_t;

  // spread active positions forward over starred tokens, parallel prefix form
  function automatic logic [NPOS-1:0] close_stars(input logic [NPOS-1:0] v,
                                                  input logic [MAX_TOKENS-1:0] p);
    logic [NPOS-1:0] g;
    logic [NPOS-1:0] pp;
    logic [NPOS-1:0] g_n;
    logic [NPOS-1:0] pp_n;
    g = v;
    pp[0] = 1'b0;
    for (int j = 1; j < NPOS; j++) begin
      pp[j] = p[j-1];
    end
    for (int lvl = 0; lvl < LEVELS; lvl++) begin
      for (int j = 0; j < NPOS; j++) begin
        if (j >= (1 << lvl)) begin
          g_n[j]  = g[j] | (pp[j] & g[j - (1 << lvl)]);
          pp_n[j] = pp[j] & pp[j - (1 << lvl)];
        end else begin
          g_n[j]  = g[j];
          pp_n[j] = pp[j];
        end
      end
      g  = g_n;
      pp = pp_n;
    end
    return g;
  endfunction

endpackage
`default_nettype wire

### design/wildcard_star_regex_matcher.sv
// top level: whole-string matcher for literal, dot and star patterns
// result path: an end word is held in the queue, then its result goes to the result register and
//   shows on out_valid; words queued ahead of it delay it further
// throughput: one word per cycle, set by the active-vector update
//   in the back end; an end word waits only while a prior result is not taken
// reset: synchronous rst_n empties the queue and result register, clears token
//   count and error flag and arms position zero only; the token store is not cleared
`default_nettype none
module wildcard_star_regex_matcher (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire wsrm_pkg::in_word_t  in_word,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output wsrm_pkg::out_word_t      out_word
);

  // classified word between front and back
  logic           cmd_valid;
  wsrm_pkg::cmd_t cmd;
  logic           cmd_pop;

  // front: takes words whenever the queue has room
  wsrm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  // back: pattern store, nfa vector, result register
  wsrm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

endmodule
`default_nettype wire

### design/wsrm_front.sv
// front end: accepts input words, classifies them and holds them in a two-entry queue
`default_nettype none
module wsrm_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire wsrm_pkg::in_word_t in_word,
  output logic                   cmd_valid,
  output wsrm_pkg::cmd_t         cmd,
  input  wire logic              cmd_pop
);

  wsrm_pkg::cmd_t q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  wsrm_pkg::cmd_t dec;
  logic       push;
  logic       pop;

  // classify
  always_comb begin
    dec.data_byte = in_word.data_byte;
    dec.is_dot    = (in_word.data_byte == wsrm_pkg::CH_DOT);
    case (in_word.kind)
      wsrm_pkg::KIND_APPEND: begin
        dec.op = (in_word.data_byte == wsrm_pkg::CH_STAR) ? wsrm_pkg::OP_STAR
                                                           : wsrm_pkg::OP_TOKEN;
      end
      wsrm_pkg::KIND_SUBJECT: dec.op = wsrm_pkg::OP_SUBJECT;
      wsrm_pkg::KIND_END:     dec.op = wsrm_pkg::OP_END;
      default:                dec.op = wsrm_pkg::OP_CLEAR;
    endcase
  end

  assign in_ready  = (cnt_r != 2'd2);
  assign push      = in_valid & in_ready;
  assign cmd_valid = (cnt_r != 2'd0);
  assign pop       = cmd_pop & cmd_valid;
  assign cmd       = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= dec;
    end
  end

endmodule
`default_nettype wire

### design/wsrm_back.sv
// back end: token store, active-position vector update and registered result
`default_nettype none
module wsrm_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cmd_valid,
  input  wire wsrm_pkg::cmd_t      cmd,
  output logic                     cmd_pop,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output wsrm_pkg::out_word_t      out_word
);

  localparam int MT   = wsrm_pkg::MAX_TOKENS;
  localparam int NP   = wsrm_pkg::NPOS;
  localparam int CW   = wsrm_pkg::CNT_W;
  localparam int IW   = wsrm_pkg::TOK_IDX_W;

  logic [7:0]    tok_byte_r [MT];
  logic [MT-1:0] tok_any_r;
  logic [MT-1:0] tok_star_r;

  logic [CW-1:0] count_r, count_nxt;
  logic          err_r, err_nxt;
  logic          last_star_r, last_star_nxt;
  logic [NP-1:0] active_r, active_nxt;
  logic          out_valid_r, out_valid_nxt;
  wsrm_pkg::out_word_t out_word_r, out_word_nxt;

  logic [MT-1:0] tok_valid;
  logic [NP-1:0] closed;
  logic [NP-1:0] step_vec;
  logic          tok_wr;
  logic          star_wr;
  logic [IW-1:0] wr_idx;
  logic [IW-1:0] star_idx;
  logic          full;
  logic          go;

  // end words wait while the result register is still held
  assign cmd_pop = cmd_valid & ((cmd.op != wsrm_pkg::OP_END) | ~out_valid_r | out_ready);
  assign go      = cmd_pop;

  assign full     = (count_r == CW'(MT));
  assign wr_idx   = count_r[IW-1:0];
  assign star_idx = IW'(count_r - CW'(1));

  always_comb begin
    for (int i = 0; i < MT; i++) begin
      tok_valid[i] = (CW'(i) < count_r);
    end
  end

  assign closed = wsrm_pkg::close_stars(active_r, tok_valid & tok_star_r);

  // one subject byte through the automaton
  always_comb begin
    step_vec = '0;
    for (int i = 0; i < MT; i++) begin
      if (tok_valid[i] && closed[i] &&
          (tok_any_r[i] || (tok_byte_r[i] == cmd.data_byte))) begin
        if (tok_star_r[i]) begin
          step_vec[i] = 1'b1;
        end else begin
          step_vec[i+1] = 1'b1;
        end
      end
    end
  end

  always_comb begin
    count_nxt     = count_r;
    err_nxt       = err_r;
    last_star_nxt = last_star_r;
    active_nxt    = active_r;
    out_word_nxt  = out_word_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    tok_wr        = 1'b0;
    star_wr       = 1'b0;
    if (go) begin
      case (cmd.op)
        wsrm_pkg::OP_TOKEN: begin
          if (full) begin
            err_nxt = 1'b1;
          end else begin
            tok_wr        = 1'b1;
            count_nxt     = count_r + CW'(1);
            last_star_nxt = 1'b0;
          end
          active_nxt = NP'(1);
        end
        wsrm_pkg::OP_STAR: begin
          if ((count_r == '0) || last_star_r) begin
            err_nxt = 1'b1;
          end else begin
            star_wr       = 1'b1;
            last_star_nxt = 1'b1;
          end
          active_nxt = NP'(1);
        end
        wsrm_pkg::OP_SUBJECT: begin
          active_nxt = step_vec;
        end
        wsrm_pkg::OP_END: begin
          out_word_nxt.matched       = closed[count_r] & ~err_r;
          out_word_nxt.pattern_error = err_r;
          out_valid_nxt              = 1'b1;
          active_nxt                 = NP'(1);
        end
        default: begin
          count_nxt     = '0;
          err_nxt       = 1'b0;
          last_star_nxt = 1'b0;
          active_nxt    = NP'(1);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      err_r       <= 1'b0;
      last_star_r <= 1'b0;
      active_r    <= NP'(1);
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      err_r       <= err_nxt;
      last_star_r <= last_star_nxt;
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

  // token store, no reset
  always_ff @(posedge clk) begin
    if (tok_wr) begin
      tok_byte_r[wr_idx] <= cmd.data_byte;
      tok_any_r[wr_idx]  <= cmd.is_dot;
      tok_star_r[wr_idx] <= 1'b0;
    end else if (star_wr) begin
      tok_star_r[star_idx] <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule
`default_nettype wire

### design/wsrm_checker.sv
// checker: port-level properties of the regex matcher, bound to the top level
`default_nettype none
module wsrm_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire wsrm_pkg::in_word_t  in_word,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire wsrm_pkg::out_word_t out_word
);

  // a waiting input word stays put
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_word))
    else $error("input word changed while waiting");

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("result changed while stalled");

  // a bad pattern never reports a match
  a_err_no_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_word.matched && out_word.pattern_error))
    else $error("match reported with pattern error");

  // no result right out of reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // queue empty after reset, so input is ready
  a_reset_ready: assert property (@(posedge clk)
    !rst_n |=> in_ready)
    else $error("input not ready after reset");

endmodule

bind wildcard_star_regex_matcher wsrm_checker u_wsrm_checker (.*);
`default_nettype wire

### bench/tb_wildcard_star_regex_matcher.sv
// testbench for the wildcard star regex matcher: directed and random words checked against an nfa predictor
`timescale 1ns / 100ps
module tb_wildcard_star_regex_matcher;

  localparam int MT = wsrm_pkg::MAX_TOKENS;
  localparam int NP = wsrm_pkg::NPOS;

  // no-handshake cycles tolerated while work is pending
  localparam int STALL_LIMIT  = 1000;
  // settle time after the last verdict, well past the result latency
  localparam int DRAIN_CYCLES = 10;
  localparam int RANDOM_WORDS = 400;

  // one token as the predictor keeps it
  typedef struct packed {
    logic       starred;
    logic       any;
    logic [7:0] ch;
  } pat_tok_t;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  wsrm_pkg::in_word_t  in_word   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  wsrm_pkg::out_word_t out_word;

  // words waiting to be driven, verdicts waiting to come out
  wsrm_pkg::in_word_t  pending_words[$];
  wsrm_pkg::out_word_t expected_verdicts[$];

  // predictor copy of the matcher state
  pat_tok_t      pat_tok [MT];
  int            pat_len  = 0;
  logic [NP-1:0] live_pos = NP'(1);
  logic          pat_bad  = 1'b0;

  // pattern plan of the sequence being generated, used to build subjects that fit
  logic [7:0] plan_ch[$];
  bit         plan_star[$];

  int   words_in      = 0;
  int   verdicts_seen = 0;
  int   matches_seen  = 0;
  int   errors_seen   = 0;
  int   fails         = 0;
  int   stall_cycles  = 0;
  int   directed_n    = 0;
  logic in_fired      = 1'b0;
  logic calm;

  // a long stretch in the middle of the run with no idling on either side
  assign calm = (words_in >= 150) && (words_in < 250);

  wildcard_star_regex_matcher dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  always #6 clk = ~clk;

  // positions that a starred token lets the match skip over, in one forward pass
  function automatic logic [NP-1:0] skip_starred(input logic [NP-1:0] v);
    logic [NP-1:0] r;
    r = v;
    for (int i = 0; i < pat_len; i++) begin
      if (r[i] && pat_tok[i].starred) r[i+1] = 1'b1;
    end
    return r;
  endfunction

  // advance the predictor by one accepted word, queue a verdict on an end word
  task automatic predict_word(input wsrm_pkg::in_word_t w);
    logic [NP-1:0]       cur;
    logic [NP-1:0]       nxt;
    wsrm_pkg::out_word_t verdict;
    case (w.kind)
      wsrm_pkg::KIND_APPEND: begin
        if (w.data_byte == wsrm_pkg::CH_STAR) begin
          // leading star, or a star on a token that already has one
          if (pat_len == 0) begin
            pat_bad = 1'b1;
          end else if (pat_tok[pat_len-1].starred) begin
            pat_bad = 1'b1;
          end else begin
            pat_tok[pat_len-1].starred = 1'b1;
          end
        end else if (pat_len >= MT) begin
          // store full, token dropped
          pat_bad = 1'b1;
        end else begin
          pat_tok[pat_len].starred = 1'b0;
          pat_tok[pat_len].any     = (w.data_byte == wsrm_pkg::CH_DOT);
          pat_tok[pat_len].ch      = w.data_byte;
          pat_len++;
        end
        // any pattern change restarts the subject
        live_pos = NP'(1);
      end
      wsrm_pkg::KIND_SUBJECT: begin
        cur = skip_starred(live_pos);
        nxt = '0;
        for (int i = 0; i < pat_len; i++) begin
          if (cur[i] && (pat_tok[i].any || pat_tok[i].ch == w.data_byte)) begin
            if (pat_tok[i].starred) nxt[i] = 1'b1;
            else nxt[i+1] = 1'b1;
          end
        end
        live_pos = nxt;
      end
      wsrm_pkg::KIND_END: begin
        cur = skip_starred(live_pos);
        verdict.matched       = cur[pat_len] && !pat_bad;
        verdict.pattern_error = pat_bad;
        expected_verdicts.push_back(verdict);
        live_pos = NP'(1);
      end
      default: begin
        pat_len  = 0;
        pat_bad  = 1'b0;
        live_pos = NP'(1);
      end
    endcase
  endtask

  task automatic add_word(input logic [1:0] k, input logic [7:0] b);
    wsrm_pkg::in_word_t w;
    w.kind      = k;
    w.data_byte = b;
    pending_words.push_back(w);
  endtask

  // mostly a small alphabet so that patterns and subjects meet often
  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(99);
    if (r < 45) return "a";
    else if (r < 70) return "b";
    else if (r < 85) return wsrm_pkg::CH_DOT;
    else return 8'($urandom);
  endfunction

  // clear, a clean pattern, then a few subjects built to fit it, some of them spoiled
  task automatic gen_well_formed(input bit force_full);
    int         ntok;
    int         nsub;
    int         reps;
    logic [7:0] c;
    logic [7:0] subj[$];
    add_word(wsrm_pkg::KIND_CLEAR, 8'($urandom));
    plan_ch.delete();
    plan_star.delete();
    if (force_full) ntok = MT + 2;
    else if ($urandom_range(99) < 8) ntok = $urandom_range(MT + 2, MT - 2);
    else ntok = $urandom_range(6, 0);
    for (int i = 0; i < ntok; i++) begin
      c = pick_byte();
      if (c == wsrm_pkg::CH_STAR) c = "c";
      plan_ch.push_back(c);
      plan_star.push_back($urandom_range(99) < 35);
      add_word(wsrm_pkg::KIND_APPEND, c);
      if (plan_star[i]) add_word(wsrm_pkg::KIND_APPEND, wsrm_pkg::CH_STAR);
    end
    nsub = $urandom_range(3, 1);
    repeat (nsub) begin
      subj.delete();
      foreach (plan_ch[i]) begin
        reps = plan_star[i] ? $urandom_range(3, 0) : 1;
        repeat (reps) begin
          subj.push_back((plan_ch[i] == wsrm_pkg::CH_DOT) ? 8'($urandom) : plan_ch[i]);
        end
      end
      // spoil about a third: replace, drop or add a byte
      if ($urandom_range(99) < 30) begin
        case ($urandom_range(2))
          0: if (subj.size() != 0) subj[$urandom_range(subj.size() - 1)] = pick_byte();
          1: if (subj.size() != 0) subj.delete($urandom_range(subj.size() - 1));
          default: subj.push_back(pick_byte());
        endcase
      end
      foreach (subj[j]) add_word(wsrm_pkg::KIND_SUBJECT, subj[j]);
      add_word(wsrm_pkg::KIND_END, 8'($urandom));
    end
  endtask

  // random kinds and star-heavy bytes: misplaced stars, pattern edits mid subject
  task automatic gen_noise();
    int         n;
    logic [7:0] b;
    n = $urandom_range(8, 2);
    repeat (n) begin
      case ($urandom_range(2))
        0: b = wsrm_pkg::CH_STAR;
        1: b = pick_byte();
        default: b = 8'($urandom);
      endcase
      add_word(2'($urandom_range(3)), b);
    end
    add_word(wsrm_pkg::KIND_END, 8'($urandom));
  endtask

  // driver: change inputs on the falling edge, hold a word until it is taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (!in_valid || in_fired) begin
        if (pending_words.size() != 0 && (calm || $urandom_range(99) >= 15)) begin
          in_word  <= pending_words.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= calm || ($urandom_range(99) >= 15);
    end
  end

  // monitor: check results first, then predict from the accepted input word
  always @(posedge clk) begin
    wsrm_pkg::out_word_t want;
    in_fired <= rst_n && in_valid && in_ready;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_verdicts.size() == 0) begin
          fails++;
          $display("%0t: unexpected result word: matched=%0b pattern_error=%0b",
                   $time, out_word.matched, out_word.pattern_error);
        end else begin
          want = expected_verdicts.pop_front();
          if (out_word.matched !== want.matched) begin
            fails++;
            $display("%0t: matched mismatch: expected %0b actual %0b",
                     $time, want.matched, out_word.matched);
          end
          if (out_word.pattern_error !== want.pattern_error) begin
            fails++;
            $display("%0t: pattern_error mismatch: expected %0b actual %0b",
                     $time, want.pattern_error, out_word.pattern_error);
          end
          verdicts_seen++;
          if (out_word.matched === 1'b1) matches_seen++;
          if (out_word.pattern_error === 1'b1) errors_seen++;
        end
      end
      if (in_valid && in_ready) begin
        predict_word(in_word);
        words_in++;
      end
      // watchdog only runs while something is still owed
      if ((in_valid && in_ready) || (out_valid && out_ready) ||
          (pending_words.size() == 0 && !in_valid && expected_verdicts.size() == 0)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: watchdog: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    // empty pattern: empty subject matches, any byte does not
    add_word(wsrm_pkg::KIND_END, 8'h00);
    add_word(wsrm_pkg::KIND_SUBJECT, 8'hFF);
    add_word(wsrm_pkg::KIND_END, 8'hFF);
    // starred literal: zero and two repeats
    add_word(wsrm_pkg::KIND_CLEAR, 8'hFF);
    add_word(wsrm_pkg::KIND_APPEND, "a");
    add_word(wsrm_pkg::KIND_APPEND, wsrm_pkg::CH_STAR);
    add_word(wsrm_pkg::KIND_END, 8'h00);
    add_word(wsrm_pkg::KIND_SUBJECT, "a");
    add_word(wsrm_pkg::KIND_SUBJECT, "a");
    add_word(wsrm_pkg::KIND_END, 8'h00);
    // dot then literal 0xff, with extreme subject bytes
    add_word(wsrm_pkg::KIND_CLEAR, 8'h00);
    add_word(wsrm_pkg::KIND_APPEND, wsrm_pkg::CH_DOT);
    add_word(wsrm_pkg::KIND_APPEND, 8'hFF);
    add_word(wsrm_pkg::KIND_SUBJECT, 8'h00);
    add_word(wsrm_pkg::KIND_SUBJECT, 8'hFF);
    add_word(wsrm_pkg::KIND_END, 8'h00);
    // pattern grows in the middle of a subject, which restarts it
    add_word(wsrm_pkg::KIND_SUBJECT, 8'h55);
    add_word(wsrm_pkg::KIND_APPEND, 8'h00);
    add_word(wsrm_pkg::KIND_END, 8'hAA);
    // leading star, sticky error
    add_word(wsrm_pkg::KIND_CLEAR, 8'h00);
    add_word(wsrm_pkg::KIND_APPEND, wsrm_pkg::CH_STAR);
    add_word(wsrm_pkg::KIND_END, 8'h00);
    // doubled star
    add_word(wsrm_pkg::KIND_CLEAR, 8'h00);
    add_word(wsrm_pkg::KIND_APPEND, 8'h80);
    add_word(wsrm_pkg::KIND_APPEND, wsrm_pkg::CH_STAR);
    add_word(wsrm_pkg::KIND_APPEND, wsrm_pkg::CH_STAR);
    add_word(wsrm_pkg::KIND_SUBJECT, 8'h80);
    add_word(wsrm_pkg::KIND_END, 8'h00);
    directed_n = pending_words.size();

    // first random sequence overfills the token store
    gen_well_formed(1'b1);
    while (pending_words.size() < directed_n + RANDOM_WORDS) begin
      if ($urandom_range(99) < 15) gen_noise();
      else gen_well_formed(1'b0);
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_words.size() != 0 || in_valid || expected_verdicts.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d input words (%0d directed), %0d verdicts checked",
             words_in, directed_n, verdicts_seen);
    $display("verdicts: %0d whole-subject matches, %0d with pattern errors, %0d mismatches",
             matches_seen, errors_seen, fails);
    if (fails == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
